/* sv/dct_coeff_histogram_pair_stats_assert.svh */
// ---------------------------------------------------------------------------
// dct coefficient histogram pair stats: assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef DCT_COEFF_HISTOGRAM_PAIR_STATS_ASSERT_SVH
`define DCT_COEFF_HISTOGRAM_PAIR_STATS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define DCHPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dchps assertion failed");

// next-cycle implication, disabled during reset
`define DCHPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dchps assertion failed");

`else

`define DCHPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DCHPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/dchps_pkg.sv */
// ---------------------------------------------------------------------------
// dchps_pkg
// Shared types and fixed constants of the coefficient histogram pair stats.
// ---------------------------------------------------------------------------
`default_nettype none

package dchps_pkg;

    // fixed field widths
    localparam int COEF_W     = 16;
    localparam int SUM_OUT_W  = 31;
    localparam int MEAN_OUT_W = 23;
    localparam int MAX_OUT_W  = 24;

    // fixed mean divisor
    localparam int MEAN_DIV = 200;

    // sum / 200 as (sum * MEAN_RECIP) >> MEAN_SHIFT, exact for any sum below 2^31
    localparam logic [31:0] MEAN_RECIP = 32'd2748779070;
    localparam int          MEAN_SHIFT = 39;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

/* sv/dchps_ram.sv */
// ---------------------------------------------------------------------------
// dchps_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module dchps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 201
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/dct_coeff_histogram_pair_stats.sv */
// ---------------------------------------------------------------------------
// dct_coeff_histogram_pair_stats
// Histograms quantized DCT coefficients in -HALF_RANGE..HALF_RANGE and, on
// the last beat of a set, reports sum, mean (sum / 200) and maximum of the
// absolute differences of the bin pairs (0,1), (2,3), ...
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | to block  | i_valid / o_stall  | i_coefficient, i_last_item
//  out     | from block| o_valid / i_stall  | o_pair_diff_sum, o_mean_pair_diff,
//          |           |                    | o_max_pair_diff
//
// in-range beat: bin read, then saturating write in ST_INC; others skip ST_INC
// last beat adds a scan (ST_SCAN) that also clears the bins, then
// ST_DIV for the mean (reciprocal multiply) and ST_OUT to load the result
// after reset o_stall stays high through the bin clear
// a result held by i_stall blocks input only once the next one is ready
// ---------------------------------------------------------------------------
`default_nettype none

`include "dct_coeff_histogram_pair_stats_assert.svh"

module dct_coeff_histogram_pair_stats #(
    parameter int HALF_RANGE = 100,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [dchps_pkg::COEF_W-1:0]   i_coefficient,
    input  wire logic                                  i_last_item,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [dchps_pkg::SUM_OUT_W-1:0]            o_pair_diff_sum,
    output logic [dchps_pkg::MEAN_OUT_W-1:0]           o_mean_pair_diff,
    output logic [dchps_pkg::MAX_OUT_W-1:0]            o_max_pair_diff
);

    localparam int NUM_BINS = 2 * HALF_RANGE + 1;
    localparam int ADDR_W   = $clog2(NUM_BINS);
    localparam int CNT_W    = $clog2(NUM_BINS + 1);
    localparam int SUM_W    = COUNT_BITS + $clog2(HALF_RANGE + 1);
    localparam int EXT_W    = (SUM_W > dchps_pkg::SUM_OUT_W) ? SUM_W : dchps_pkg::SUM_OUT_W;
    localparam int RECIP_W  = $bits(dchps_pkg::MEAN_RECIP);
    localparam int PROD_W   = dchps_pkg::SUM_OUT_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - dchps_pkg::MEAN_SHIFT;

    localparam logic signed [dchps_pkg::COEF_W-1:0] HR_POS =
        dchps_pkg::COEF_W'(HALF_RANGE);
    localparam logic signed [dchps_pkg::COEF_W-1:0] HR_NEG = -HR_POS;

    localparam logic [EXT_W-1:0] SUM_LIM  = EXT_W'({dchps_pkg::SUM_OUT_W{1'b1}});
    localparam logic [EXT_W-1:0] MEAN_LIM = EXT_W'({dchps_pkg::MEAN_OUT_W{1'b1}});
    localparam logic [EXT_W-1:0] MAX_LIM  = EXT_W'({dchps_pkg::MAX_OUT_W{1'b1}});

    // control registers
    dchps_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_rd_pend, n_rd_pend;
    logic              r_diff_vld, n_diff_vld;
    logic              r_out_vld, n_out_vld;

    // payload registers
    logic                          r_last, n_last;
    logic [ADDR_W-1:0]             r_rd_addr, n_rd_addr;
    logic [COUNT_BITS-1:0]         r_a, n_a;
    logic [COUNT_BITS-1:0]         r_diff, n_diff;
    logic [SUM_W-1:0]              r_sum, n_sum;
    logic [COUNT_BITS-1:0]         r_max, n_max;
    logic [QUOT_W-1:0]             r_quot, n_quot;
    logic [dchps_pkg::SUM_OUT_W-1:0]  r_out_sum, n_out_sum;
    logic [dchps_pkg::MEAN_OUT_W-1:0] r_out_mean, n_out_mean;
    logic [dchps_pkg::MAX_OUT_W-1:0]  r_out_max, n_out_max;

    // memory port signals
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [COUNT_BITS-1:0] ram_rd_data;

    // input decode
    logic                          coef_in_range;
    logic [dchps_pkg::COEF_W-1:0]  coef_offset;

    // output saturation
    logic [EXT_W-1:0] sum_ext;
    logic [EXT_W-1:0] quot_ext;
    logic [EXT_W-1:0] max_ext;
    logic [dchps_pkg::SUM_OUT_W-1:0] sum_clip;

    // mean product
    logic [PROD_W-1:0] mean_prod;

    // state decodes for the checks
    logic st_inc;
    logic st_scan;
    logic st_out;

    dchps_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // bin index of the incoming coefficient
    assign coef_in_range = (i_coefficient >= HR_NEG) && (i_coefficient <= HR_POS);
    assign coef_offset   = i_coefficient + HR_POS;

    // widened views for saturation
    assign sum_ext  = EXT_W'(r_sum);
    assign quot_ext = EXT_W'(r_quot);
    assign max_ext  = EXT_W'(r_max);
    assign sum_clip = (sum_ext > SUM_LIM) ? '1 : sum_ext[dchps_pkg::SUM_OUT_W-1:0];

    // clipped sum times the reciprocal of the mean divisor
    assign mean_prod = PROD_W'(sum_clip) * PROD_W'(dchps_pkg::MEAN_RECIP);

    // port drives
    assign o_stall          = (r_state != dchps_pkg::ST_IDLE);
    assign o_valid          = r_out_vld;
    assign o_pair_diff_sum  = r_out_sum;
    assign o_mean_pair_diff = r_out_mean;
    assign o_max_pair_diff  = r_out_max;

    assign st_inc  = (r_state == dchps_pkg::ST_INC);
    assign st_scan = (r_state == dchps_pkg::ST_SCAN);
    assign st_out  = (r_state == dchps_pkg::ST_OUT);

    // sequencer: next state and datapath
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_diff_vld = 1'b0;
        n_out_vld  = r_out_vld;
        n_last     = r_last;
        n_rd_addr  = r_rd_addr;
        n_a        = r_a;
        n_diff     = r_diff;
        n_sum      = r_sum;
        n_max      = r_max;
        n_quot     = r_quot;
        n_out_sum  = r_out_sum;
        n_out_mean = r_out_mean;
        n_out_max  = r_out_max;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_rd_addr;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_cnt[ADDR_W-1:0];

        // result beat taken downstream
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        // accumulate the registered pair difference
        if (r_diff_vld) begin
            n_sum = r_sum + SUM_W'(r_diff);
            if (r_diff > r_max) begin
                n_max = r_diff;
            end
        end

        unique case (r_state)
            dchps_pkg::ST_CLEAR: begin
                // zero sweep after reset
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_cnt[ADDR_W-1:0];
                if (r_cnt == CNT_W'(NUM_BINS - 1)) begin
                    n_cnt   = '0;
                    n_state = dchps_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dchps_pkg::ST_IDLE: begin
                // accept a beat; start the bin read, or the scan for an out-of-range last beat
                if (i_valid) begin
                    n_last = i_last_item;
                    if (coef_in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = coef_offset[ADDR_W-1:0];
                        n_state     = dchps_pkg::ST_INC;
                    end else if (i_last_item) begin
                        n_cnt   = '0;
                        n_sum   = '0;
                        n_max   = '0;
                        n_state = dchps_pkg::ST_SCAN;
                    end
                end
            end
            dchps_pkg::ST_INC: begin
                // saturating bin update
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_rd_addr;
                ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 1'b1;
                if (r_last) begin
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_max   = '0;
                    n_state = dchps_pkg::ST_SCAN;
                end else begin
                    n_state = dchps_pkg::ST_IDLE;
                end
            end
            dchps_pkg::ST_SCAN: begin
                // read one bin a cycle, clear it as its data returns
                if (r_cnt < CNT_W'(NUM_BINS)) begin
                    ram_rd_en = 1'b1;
                end
                if (r_rd_pend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_rd_addr;
                    if (!r_rd_addr[0]) begin
                        n_a = ram_rd_data;
                    end else begin
                        n_diff     = (r_a > ram_rd_data) ? r_a - ram_rd_data
                                                         : ram_rd_data - r_a;
                        n_diff_vld = 1'b1;
                    end
                end
                if (r_cnt == CNT_W'(NUM_BINS)) begin
                    n_state = dchps_pkg::ST_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dchps_pkg::ST_DIV: begin
                // mean of the clipped sum by reciprocal multiplication
                n_quot  = mean_prod[PROD_W-1:dchps_pkg::MEAN_SHIFT];
                n_state = dchps_pkg::ST_OUT;
            end
            dchps_pkg::ST_OUT: begin
                // load the result register once it is free
                if (!r_out_vld || !i_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_sum  = sum_clip;
                    n_out_mean = (quot_ext > MEAN_LIM) ? '1
                                 : quot_ext[dchps_pkg::MEAN_OUT_W-1:0];
                    n_out_max  = (max_ext > MAX_LIM) ? '1 : max_ext[dchps_pkg::MAX_OUT_W-1:0];
                    n_state    = dchps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = dchps_pkg::ST_CLEAR;
            end
        endcase

        // track the read in flight
        n_rd_pend = ram_rd_en;
        if (ram_rd_en) begin
            n_rd_addr = ram_rd_addr;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dchps_pkg::ST_CLEAR;
            r_cnt      <= '0;
            r_rd_pend  <= 1'b0;
            r_diff_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_rd_pend  <= n_rd_pend;
            r_diff_vld <= n_diff_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_rd_addr  <= n_rd_addr;
        r_a        <= n_a;
        r_diff     <= n_diff;
        r_sum      <= n_sum;
        r_max      <= n_max;
        r_quot     <= n_quot;
        r_out_sum  <= n_out_sum;
        r_out_mean <= n_out_mean;
        r_out_max  <= n_out_max;
    end

    // a held result is never overwritten by the next one
    `DCHPS_ASSERT_NXT(a_out_held, i_clk, i_rst_n, st_out && r_out_vld && i_stall, st_out)
    // the bin update always has its read data in flight
    `DCHPS_ASSERT_IMP(a_inc_has_read, i_clk, i_rst_n, st_inc, r_rd_pend)
    // pair differences only accumulate during the scan
    `DCHPS_ASSERT_IMP(a_diff_in_scan, i_clk, i_rst_n, r_diff_vld, st_scan)

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: dct coefficient histogram pair stats
// Streams sets of coefficients through the block and checks each pair-stats
// beat against a histogram predictor kept in step with the accepted input.
// ---------------------------------------------------------------------------
module testbench;

    localparam int HALF_RANGE     = 100;
    localparam int COUNT_BITS     = 24;
    localparam int NUM_BINS       = 2 * HALF_RANGE + 1;
    localparam int IDLE_PCT       = 11;
    localparam int HOLD_CYCLES    = 1500;
    localparam int TAIL_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 1350;
    localparam int SET_TARGET     = 50;

    // how the coefficients of one set are drawn
    typedef enum int {
        MIX_SPREAD,
        MIX_CLUSTER,
        MIX_NOISE,
        MIX_PAIRED
    } t_coef_mix;

    typedef struct {
        logic [dchps_pkg::SUM_OUT_W-1:0]  diff_sum;
        logic [dchps_pkg::MEAN_OUT_W-1:0] mean_diff;
        logic [dchps_pkg::MAX_OUT_W-1:0]  max_diff;
    } t_pair_stats;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic signed [dchps_pkg::COEF_W-1:0]  i_coefficient;
    logic                                 i_last_item;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic [dchps_pkg::SUM_OUT_W-1:0]      o_pair_diff_sum;
    logic [dchps_pkg::MEAN_OUT_W-1:0]     o_mean_pair_diff;
    logic [dchps_pkg::MAX_OUT_W-1:0]      o_max_pair_diff;

    // predictor state and scoreboard
    logic [COUNT_BITS-1:0]      model_bins [NUM_BINS];
    t_pair_stats                pending_stats [$];
    int                         items_sent;
    int                         sets_sent;
    int                         error_count = 0;
    int                         quiet_cycles = 0;
    int                         hold_reqs = 0;
    int                         hold_seen = 0;
    int                         hold_left = 0;
    bit                         no_idle;

    dct_coeff_histogram_pair_stats #(
        .HALF_RANGE (HALF_RANGE),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_coefficient    (i_coefficient),
        .i_last_item      (i_last_item),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pair_diff_sum  (o_pair_diff_sum),
        .o_mean_pair_diff (o_mean_pair_diff),
        .o_max_pair_diff  (o_max_pair_diff)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // clip a value to the all-ones of a field width
    function automatic longint unsigned clip(input longint unsigned value, input int width);
        longint unsigned limit;
        limit = (64'd1 << width) - 1;
        return (value > limit) ? limit : value;
    endfunction

    // histogram update, and on the last beat the pair scan and clear
    task automatic tally_coefficient(input logic signed [dchps_pkg::COEF_W-1:0] coef,
                                     input logic last);
        int              value;
        int              idx;
        longint unsigned diff_sum;
        longint unsigned max_diff;
        longint unsigned d;
        t_pair_stats     stats;
        value = coef;
        if (value >= -HALF_RANGE && value <= HALF_RANGE) begin
            idx = value + HALF_RANGE;
            if (model_bins[idx] != {COUNT_BITS{1'b1}}) begin
                model_bins[idx] = model_bins[idx] + 1'b1;
            end
        end
        if (last) begin
            diff_sum = 0;
            max_diff = 0;
            // top bin has no partner
            for (int k = 0; k + 1 < NUM_BINS; k += 2) begin
                if (model_bins[k] > model_bins[k+1]) begin
                    d = model_bins[k] - model_bins[k+1];
                end else begin
                    d = model_bins[k+1] - model_bins[k];
                end
                diff_sum += d;
                if (d > max_diff) begin
                    max_diff = d;
                end
            end
            stats.diff_sum  = clip(diff_sum, dchps_pkg::SUM_OUT_W);
            stats.mean_diff = clip(diff_sum / dchps_pkg::MEAN_DIV, dchps_pkg::MEAN_OUT_W);
            stats.max_diff  = clip(max_diff, dchps_pkg::MAX_OUT_W);
            pending_stats.push_back(stats);
            sets_sent++;
            foreach (model_bins[i]) begin
                model_bins[i] = '0;
            end
        end
    endtask

    // one input beat; entered and left at a falling edge, valid left high
    task automatic send_beat(input logic signed [dchps_pkg::COEF_W-1:0] coef,
                             input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_coefficient <= coef;
        i_last_item   <= last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        tally_coefficient(coef, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    // drop valid so nothing is re-sent
    task automatic go_quiet();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        while (pending_stats.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic signed [dchps_pkg::COEF_W-1:0] pick_coefficient(
        input t_coef_mix mix, input int center);
        int r;
        int value;
        r = $urandom_range(99);
        unique case (mix)
            MIX_NOISE: begin
                value = $urandom;
            end
            MIX_CLUSTER: begin
                if (r < 85) value = center + int'($urandom_range(6)) - 3;
                else        value = int'($urandom_range(2 * HALF_RANGE)) - HALF_RANGE;
            end
            MIX_PAIRED: begin
                if (r < 90)      value = center;
                else if (r < 95) value = center + 1;
                else             value = int'($urandom_range(2 * HALF_RANGE)) - HALF_RANGE;
            end
            default: begin
                if (r < 70)      value = int'($urandom_range(2 * HALF_RANGE)) - HALF_RANGE;
                else if (r < 80) value = $urandom_range(1) ? HALF_RANGE : -HALF_RANGE;
                else if (r < 88) value = $urandom_range(1) ? HALF_RANGE + 1 : -HALF_RANGE - 1;
                else             value = $urandom;
            end
        endcase
        return value[dchps_pkg::COEF_W-1:0];
    endfunction

    // one data set, last flag on its final beat
    task automatic send_set(input int len, input t_coef_mix mix);
        int center;
        if (mix == MIX_PAIRED) begin
            center = 2 * int'($urandom_range(HALF_RANGE - 1)) - HALF_RANGE;
        end else begin
            center = int'($urandom_range(2 * HALF_RANGE)) - HALF_RANGE;
        end
        for (int i = 0; i < len; i++) begin
            send_beat(pick_coefficient(mix, center), i == len - 1);
        end
    endtask

    // ends of the range, the unpaired top bin, sign bit
    task automatic test_bin_extremes();
        send_beat(-16'sd100, 1'b1);
        send_beat(16'sd100, 1'b1);
        send_beat(16'sd0, 1'b0);
        send_beat(16'sd0, 1'b0);
        send_beat(16'sd0, 1'b0);
        send_beat(16'sd1, 1'b1);
        send_beat(-16'sd99, 1'b0);
        send_beat(-16'sd99, 1'b1);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sd1, 1'b1);
        go_quiet();
    endtask

    // ignored coefficients, scan still runs on a last beat
    task automatic test_out_of_range();
        send_beat(16'sd101, 1'b1);
        send_beat(-16'sd101, 1'b1);
        send_beat(16'sh7fff, 1'b1);
        send_beat(16'sh8000, 1'b1);
        send_beat(-16'sd100, 1'b0);
        send_beat(16'sd5000, 1'b0);
        send_beat(16'sd99, 1'b1);
        go_quiet();
    endtask

    // no idling on either side; a long set lifts the mean above zero
    task automatic test_full_rate();
        no_idle = 1'b1;
        send_set(260, MIX_PAIRED);
        send_set(30, MIX_SPREAD);
        send_set(30, MIX_CLUSTER);
        go_quiet();
        no_idle = 1'b0;
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        hold_reqs++;
        for (int s = 0; s < 8; s++) begin
            send_set(3, MIX_SPREAD);
        end
        go_quiet();
    endtask

    // sender stops until every result is out, then resumes
    task automatic test_drain_pause();
        send_set(5, MIX_CLUSTER);
        send_set(4, MIX_SPREAD);
        go_quiet();
        wait_results_done();
        send_set(6, MIX_SPREAD);
        go_quiet();
    endtask

    // random sets: mostly well-formed, some noise and single-beat sets
    task automatic test_random_sets();
        int r;
        int big_left;
        big_left = 1;
        while (items_sent < ITEM_TARGET || sets_sent < SET_TARGET) begin
            r = $urandom_range(99);
            if (r < 3 && big_left > 0) begin
                big_left--;
                send_set($urandom_range(220, 320), MIX_PAIRED);
            end else if (r < 13) begin
                send_set($urandom_range(1, 8), MIX_NOISE);
            end else if (r < 23) begin
                send_set(1, MIX_SPREAD);
            end else if (r < 55) begin
                send_set($urandom_range(2, 40), MIX_CLUSTER);
            end else begin
                send_set($urandom_range(2, 40), MIX_SPREAD);
            end
        end
        go_quiet();
    endtask

    // receiver stall: long hold when asked, else random idling
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_pair_stats want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_stats.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat: expected none, actual sum %0d",
                         $time, o_pair_diff_sum);
            end else begin
                want = pending_stats.pop_front();
                check_field("pair_diff_sum", want.diff_sum, o_pair_diff_sum);
                check_field("mean_pair_diff", want.mean_diff, o_mean_pair_diff);
                check_field("max_pair_diff", want.max_diff, o_max_pair_diff);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_coefficient = '0;
        i_last_item   = 1'b0;
        items_sent    = 0;
        sets_sent     = 0;
        no_idle       = 1'b0;
        foreach (model_bins[i]) begin
            model_bins[i] = '0;
        end

        // reset, released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_bin_extremes();
        test_out_of_range();
        test_full_rate();
        test_backpressure();
        test_drain_pause();
        test_random_sets();

        // drain, then watch for stray beats
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_stats.size() != 0) begin
            $display("%0t: missing result beats: expected 0 pending, actual %0d",
                     $time, pending_stats.size());
        end
        if (error_count == 0 && pending_stats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
